### rtl/vdi_pkg.sv
package vdi_pkg;

    localparam int COORD_W     = 32;
    localparam int INDEX_W     = 8;
    localparam int CFG_ADDR_W  = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_UV_ENABLE     = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_ENABLE = 8'd1;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0] tex_u;
        logic [COORD_W-1:0] tex_v;
        logic [COORD_W-1:0] norm_x;
        logic [COORD_W-1:0] norm_y;
        logic [COORD_W-1:0] norm_z;
    } vdi_key_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit_hit;
        logic commit_miss;
        logic out_load;
    } vdi_cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } vdi_status_t;

endpackage

### rtl/vdi_ctrl.sv
module vdi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  vdi_pkg::vdi_status_t status,
    output vdi_pkg::vdi_cmd_t    cmd
);
    import vdi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.hit) begin
                    cmd.commit_hit = 1'b1;
                    state_next     = ST_EMIT;
                end else if (status.exhausted) begin
                    cmd.commit_miss = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // one item in flight: accept only from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted item did not start a scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result load lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.hit && status.exhausted) |-> 1'b0)
        else $error("hit and exhausted together");

endmodule

### rtl/vdi_datapath.sv
module vdi_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [vdi_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [vdi_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_mesh_start,
    input  vdi_pkg::vdi_key_t                   in_key,
    input  vdi_pkg::vdi_cmd_t                   cmd,
    output vdi_pkg::vdi_status_t                status,
    output logic [vdi_pkg::INDEX_W-1:0]         out_vert_idx,
    output logic                                out_is_new,
    output logic                                out_table_full
);
    import vdi_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic                uv_en_reg;
    logic                norm_en_reg;
    vdi_key_t            key_reg;
    vdi_key_t            mem [TABLE_DEPTH];
    vdi_key_t            rd_data_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       rd_addr_reg;
    logic [CW-1:0]       cmp_addr_reg;
    logic                cmp_valid_reg;
    logic [INDEX_W-1:0]  res_index_reg;
    logic                res_new_reg;
    logic                res_full_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_new_reg;
    logic                out_full_reg;
    vdi_key_t            key_masked;
    logic                rd_issue;
    logic                table_is_full;
    logic [CW+INDEX_W-1:0] hit_ext;
    logic [CW+INDEX_W-1:0] miss_ext;

    always_comb begin
        key_masked = in_key;
        if (!uv_en_reg) begin
            key_masked.tex_u = '0;
            key_masked.tex_v = '0;
        end
        if (!norm_en_reg) begin
            key_masked.norm_x = '0;
            key_masked.norm_y = '0;
            key_masked.norm_z = '0;
        end
    end

    assign rd_issue         = cmd.scan_en && (rd_addr_reg < count_reg);
    assign table_is_full    = (count_reg >= DEPTH_C);
    assign hit_ext          = {{INDEX_W{1'b0}}, cmp_addr_reg};
    assign miss_ext         = {{INDEX_W{1'b0}}, count_reg};
    assign status.hit       = cmp_valid_reg && (rd_data_reg == key_reg);
    assign status.exhausted = !cmp_valid_reg && (rd_addr_reg >= count_reg);

    assign out_vert_idx     = out_index_reg;
    assign out_is_new       = out_new_reg;
    assign out_table_full   = out_full_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uv_en_reg   <= 1'b0;
            norm_en_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_addr == REG_UV_ENABLE) begin
                uv_en_reg <= cfg_data[0];
            end
            if (cfg_addr == REG_NORMAL_ENABLE) begin
                norm_en_reg <= cfg_data[0];
            end
        end
    end

    // entry count and scan pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= rd_issue;
            if (cmd.load) begin
                rd_addr_reg <= '0;
                if (in_mesh_start) begin
                    count_reg <= '0;
                end
            end else if (rd_issue) begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            if (cmd.commit_miss && !table_is_full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // key table
    always_ff @(posedge aclk) begin
        if (cmd.commit_miss && !table_is_full) begin
            mem[count_reg[AW-1:0]] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr_reg[AW-1:0]];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_masked;
        end
        if (rd_issue) begin
            cmp_addr_reg <= rd_addr_reg;
        end
        if (cmd.commit_hit) begin
            res_index_reg <= hit_ext[INDEX_W-1:0];
            res_new_reg   <= 1'b0;
            res_full_reg  <= 1'b0;
        end else if (cmd.commit_miss) begin
            res_index_reg <= table_is_full ? '0 : miss_ext[INDEX_W-1:0];
            res_new_reg   <= !table_is_full;
            res_full_reg  <= table_is_full;
        end
        if (cmd.out_load) begin
            out_index_reg <= res_index_reg;
            out_new_reg   <= res_new_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit_miss && !table_is_full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        status.hit |-> (cmp_addr_reg < count_reg))
        else $error("hit on entry beyond count");

endmodule

### rtl/vertex_dedup_indexer_core.sv
// Vertex deduplication: each vertex is looked up by exact bit pattern of its enabled fields
// against the unique vertices stored so far, one table read and one full-key compare per cycle.
// The lookup is a linear scan over the key memory: a hit on entry i waits for the
// reads of the entries below it, and a miss for the reads of every stored entry.
// One item is worked at a time and the next is accepted in the cycle after the
// result is loaded; a new item is accepted while the previous result waits in the
// output register. The table needs no clearing pass: entries at or above the entry
// count are never read.
module vertex_dedup_indexer_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vdi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [vdi_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mesh_start,
    input  logic [vdi_pkg::COORD_W-1:0]        s_pos_x,
    input  logic [vdi_pkg::COORD_W-1:0]        s_pos_y,
    input  logic [vdi_pkg::COORD_W-1:0]        s_pos_z,
    input  logic [vdi_pkg::COORD_W-1:0]        s_tex_u,
    input  logic [vdi_pkg::COORD_W-1:0]        s_tex_v,
    input  logic [vdi_pkg::COORD_W-1:0]        s_norm_x,
    input  logic [vdi_pkg::COORD_W-1:0]        s_norm_y,
    input  logic [vdi_pkg::COORD_W-1:0]        s_norm_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vdi_pkg::INDEX_W-1:0]        m_vert_idx,
    output logic                               m_is_new,
    output logic                               m_table_full
);
    import vdi_pkg::*;

    vdi_cmd_t    cmd;
    vdi_status_t status;
    vdi_key_t    in_key;

    assign cfg_ready = 1'b1;

    assign in_key.pos_x  = s_pos_x;
    assign in_key.pos_y  = s_pos_y;
    assign in_key.pos_z  = s_pos_z;
    assign in_key.tex_u  = s_tex_u;
    assign in_key.tex_v  = s_tex_v;
    assign in_key.norm_x = s_norm_x;
    assign in_key.norm_y = s_norm_y;
    assign in_key.norm_z = s_norm_z;

    vdi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vdi_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .in_mesh_start    (s_mesh_start),
        .in_key           (in_key),
        .cmd              (cmd),
        .status           (status),
        .out_vert_idx     (m_vert_idx),
        .out_is_new       (m_is_new),
        .out_table_full   (m_table_full)
    );

endmodule

### dv/tb_vertex_dedup_indexer_core.sv
`timescale 1ns / 1ps

module tb_vertex_dedup_indexer_core;
    import vdi_pkg::*;

    localparam int DEPTH       = 256;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [INDEX_W-1:0] vert_idx;
        logic               is_new;
        logic               table_full;
    } idx_result_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr       = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_mesh_start   = 1'b0;
    logic [COORD_W-1:0]    s_pos_x        = '0;
    logic [COORD_W-1:0]    s_pos_y        = '0;
    logic [COORD_W-1:0]    s_pos_z        = '0;
    logic [COORD_W-1:0]    s_tex_u        = '0;
    logic [COORD_W-1:0]    s_tex_v        = '0;
    logic [COORD_W-1:0]    s_norm_x       = '0;
    logic [COORD_W-1:0]    s_norm_y       = '0;
    logic [COORD_W-1:0]    s_norm_z       = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [INDEX_W-1:0]    m_vert_idx;
    logic                  m_is_new;
    logic                  m_table_full;

    // mirror of the unique vertex table
    vdi_key_t    uniq_keys [DEPTH];
    int unsigned key_count = 0;
    logic        uv_on     = 1'b0;
    logic        norm_on   = 1'b0;

    idx_result_t expected_idx_q [$];

    int   n_errors   = 0;
    int   n_vertices = 0;
    int   n_new      = 0;
    int   n_reused   = 0;
    int   n_full     = 0;
    int   n_cfg      = 0;
    int   idle_cycles = 0;

    bit   gaps_on    = 1'b1;
    int   burst_left = 0;
    int   ready_pct  = 100;
    logic hold_req   = 1'b0;
    logic hold_ack   = 1'b0;
    int   hold_left  = 0;
    int   stall_left = 0;

    vertex_dedup_indexer_core #(.TABLE_DEPTH(DEPTH)) u_top (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic idx_result_t lookup_vertex(input logic mesh_start, input vdi_key_t raw);
        vdi_key_t    k;
        idx_result_t r;
        int          hit;
        k = raw;
        if (!uv_on) begin
            k.tex_u = '0;
            k.tex_v = '0;
        end
        if (!norm_on) begin
            k.norm_x = '0;
            k.norm_y = '0;
            k.norm_z = '0;
        end
        if (mesh_start)
            key_count = 0;
        hit = -1;
        for (int i = 0; i < key_count; i++) begin
            if (hit < 0 && uniq_keys[i] == k)
                hit = i;
        end
        r = '0;
        if (hit >= 0) begin
            r.vert_idx = hit[INDEX_W-1:0];
        end else if (key_count >= DEPTH) begin
            r.table_full = 1'b1;
        end else begin
            uniq_keys[key_count] = k;
            r.vert_idx = key_count[INDEX_W-1:0];
            r.is_new = 1'b1;
            key_count++;
        end
        return r;
    endfunction

    // receiver: random short stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(99) >= ready_pct) begin
            stall_left <= $urandom_range(7);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        vdi_key_t    key;
        idx_result_t want;
        logic        moved;
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                n_cfg++;
                if (cfg_addr == REG_UV_ENABLE)
                    uv_on = cfg_data[0];
                else if (cfg_addr == REG_NORMAL_ENABLE)
                    norm_on = cfg_data[0];
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                key = {s_pos_x, s_pos_y, s_pos_z, s_tex_u, s_tex_v,
                       s_norm_x, s_norm_y, s_norm_z};
                want = lookup_vertex(s_mesh_start, key);
                n_vertices++;
                if (want.is_new)
                    n_new++;
                else if (want.table_full)
                    n_full++;
                else
                    n_reused++;
                expected_idx_q = {expected_idx_q, want};
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_idx_q.size() == 0) begin
                    $error("result with no vertex pending: index %0d", m_vert_idx);
                    n_errors++;
                end else begin
                    want = expected_idx_q.pop_front();
                    if (m_vert_idx !== want.vert_idx) begin
                        $error("vert_idx: expected %0d, got %0d",
                               want.vert_idx, m_vert_idx);
                        n_errors++;
                    end
                    if (m_is_new !== want.is_new) begin
                        $error("is_new: expected %0b, got %0b", want.is_new, m_is_new);
                        n_errors++;
                    end
                    if (m_table_full !== want.table_full) begin
                        $error("table_full: expected %0b, got %0b",
                               want.table_full, m_table_full);
                        n_errors++;
                    end
                end
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FC0_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vdi_key_t rand_key();
        vdi_key_t k;
        k.pos_x  = rand_coord();
        k.pos_y  = rand_coord();
        k.pos_z  = rand_coord();
        k.tex_u  = rand_coord();
        k.tex_v  = rand_coord();
        k.norm_x = rand_coord();
        k.norm_y = rand_coord();
        k.norm_z = rand_coord();
        return k;
    endfunction

    task automatic send_vertex(input logic mesh_start, input vdi_key_t v);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 10);
            end
            burst_left--;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mesh_start <= mesh_start;
        s_pos_x      <= v.pos_x;
        s_pos_y      <= v.pos_y;
        s_pos_z      <= v.pos_z;
        s_tex_u      <= v.tex_u;
        s_tex_v      <= v.tex_v;
        s_norm_x     <= v.norm_x;
        s_norm_y     <= v.norm_y;
        s_norm_z     <= v.norm_z;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_idx_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_enables(input logic uv, input logic nrm);
        logic [CFG_DATA_W-1:0] data;
        wait_for_results();
        data = $urandom;
        data[0] = uv;
        write_reg(REG_UV_ENABLE, data);
        data = $urandom;
        data[0] = nrm;
        write_reg(REG_NORMAL_ENABLE, data);
    endtask

    // meshes of random size: mostly reuse of earlier vertices, some near misses
    task automatic run_meshes(input int n_items);
        vdi_key_t pool [$];
        vdi_key_t v;
        logic     start;
        int       mesh_left;
        int       sent;
        int       roll;
        sent = 0;
        mesh_left = 0;
        while (sent < n_items) begin
            start = 1'b0;
            if (mesh_left == 0) begin
                pool.delete();
                mesh_left = $urandom_range(8, 60);
                start = 1'b1;
            end
            roll = $urandom_range(99);
            if (pool.size() == 0 || roll < 35) begin
                v = rand_key();
                pool = {pool, v};
            end else if (roll < 85) begin
                v = pool[$urandom_range(pool.size() - 1)];
            end else if (roll < 95) begin
                v = pool[$urandom_range(pool.size() - 1)];
                v[$urandom_range(255)] ^= 1'b1;
            end else begin
                // stray mesh start in the middle of a mesh
                v = pool[$urandom_range(pool.size() - 1)];
                start = 1'b1;
                pool.delete();
                pool = {pool, v};
            end
            send_vertex(start, v);
            sent++;
            mesh_left--;
        end
    endtask

    task automatic test_masking_and_regs();
        vdi_key_t zeros, ones, pos_only, neg_zero;
        zeros = '0;
        ones  = '1;
        pos_only = '0;
        pos_only.pos_x = '1;
        pos_only.pos_y = '1;
        pos_only.pos_z = '1;
        neg_zero = {8{32'h8000_0000}};
        neg_zero.pos_x = '0;
        neg_zero.pos_y = '0;
        neg_zero.pos_z = '0;
        gaps_on   = 1'b0;
        ready_pct = 100;
        // enables still at reset: texture and normal ignored
        send_vertex(1'b1, zeros);
        send_vertex(1'b0, ones);
        send_vertex(1'b0, pos_only);
        send_vertex(1'b0, neg_zero);
        wait_for_results();
        write_reg(REG_UV_ENABLE, 32'hFFFF_FFFF);
        write_reg(REG_NORMAL_ENABLE, 32'h0000_0003);
        send_vertex(1'b0, ones);
        send_vertex(1'b0, pos_only);
        send_vertex(1'b0, zeros);
        send_vertex(1'b0, ones ^ {32'h0, 32'h0, 32'h0, 32'h1, 128'h0});
        send_vertex(1'b0, ones ^ {224'h0, 32'h8000_0000});
        send_vertex(1'b0, ones);
        // mesh start on a vertex already in the table
        send_vertex(1'b1, ones);
        send_vertex(1'b0, zeros);
        wait_for_results();
        write_reg(8'd2, 32'h0000_0001);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(REG_UV_ENABLE, 32'hFFFF_FFFE);
        send_vertex(1'b0, ones);
        send_vertex(1'b0, neg_zero);
        send_vertex(1'b0, zeros);
    endtask

    task automatic test_table_full();
        vdi_key_t fill [DEPTH];
        vdi_key_t v;
        set_enables(1'b1, 1'b1);
        gaps_on   = 1'b0;
        ready_pct = 100;
        for (int i = 0; i < DEPTH; i++) begin
            v = rand_key();
            v.pos_x[7:0] = i[7:0];
            v.pos_y = 32'h3F80_0000;
            fill[i] = v;
            send_vertex(i == 0, v);
        end
        gaps_on   = 1'b1;
        ready_pct = 60;
        for (int i = 0; i < 12; i++) begin
            case (i % 4)
                0: v = rand_key();
                1: v = fill[DEPTH - 1];
                2: v = fill[$urandom_range(DEPTH - 1)];
                default: begin
                    v = fill[$urandom_range(DEPTH - 1)];
                    v[$urandom_range(255)] ^= 1'b1;
                end
            endcase
            send_vertex(1'b0, v);
        end
        send_vertex(1'b0, fill[0]);
        send_vertex(1'b1, fill[DEPTH - 1]);
        send_vertex(1'b0, fill[0]);
    endtask

    task automatic test_output_hold_off();
        set_enables(1'b0, 1'b1);
        gaps_on   = 1'b0;
        ready_pct = 100;
        hold_req <= ~hold_req;
        run_meshes(16);
    endtask

    task automatic test_random_meshes();
        set_enables(1'b0, 1'b0);
        gaps_on   = 1'b1;
        ready_pct = 100;
        run_meshes(25);
        set_enables(1'b1, 1'b1);
        ready_pct = 70;
        run_meshes(25);
        set_enables(1'b0, 1'b1);
        gaps_on   = 1'b0;
        ready_pct = 40;
        run_meshes(25);
        set_enables(1'b1, 1'b0);
        gaps_on   = 1'b1;
        ready_pct = 85;
        run_meshes(25);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_masking_and_regs();
        test_table_full();
        test_output_hold_off();
        test_random_meshes();
        wait_for_results();
        repeat (20) @(posedge aclk);
        $display("%0d vertices checked: %0d new, %0d reused, %0d refused by a full table",
                 n_vertices, n_new, n_reused, n_full);
        $display("%0d register writes over four enable settings, one long output hold-off",
                 n_cfg);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
